>>> rtl/gdbd_pkg.sv
// ----------------------------------------------------------------------------
// gdbd_pkg
// Types, constants and helper functions for the Gregorian days-between block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdbd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 22;
  localparam int COUNT_W = 23;
  localparam int QUOT_W  = 8;
  localparam int BASE_W  = 9;

  localparam logic [DIFF_W-1:0]  DIFF_MAX     = {DIFF_W{1'b1}};
  localparam logic [8:0]         DAYS_IN_YEAR = 9'd365;
  localparam logic [12:0]        RECIP_25     = 13'd5243;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_LEAP_DAY = 5'd29;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
    logic               include_end_day;
  } in_word_t;

  typedef struct packed {
    logic [DIFF_W-1:0] day_difference;
    logic              date_invalid;
  } out_word_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ok;
  } lane_res_t;

  function automatic logic [BASE_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [BASE_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // quotient by 25 for values below 4096
  function automatic logic [QUOT_W-1:0] div25(input logic [11:0] q);
    logic [24:0] prod;
    prod = q * RECIP_25;
    return prod[24:17];
  endfunction

endpackage

`default_nettype wire

>>> rtl/gregorian_days_between_dates_top.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_top
// Days between two Gregorian dates, one date pair per cycle.
//
// The in_ channel takes a word with two dates and an include-end-day flag;
// the out_ channel returns one word per input: the absolute day difference
// (plus one when the flag is set) and an invalid flag that forces the
// difference to zero. Both channels use valid/ready.
// Each date runs through its own two-stage conversion lane; a merge stage
// forms the difference. Three register stages in all, and one word is
// accepted every cycle while the receiver keeps up.
// The pipeline advances as a whole: when out_valid is high and out_ready
// is low, every stage holds and in_ready drops until the result is taken.
// Synchronous reset clears all valid flags; no results are pending after it.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_days_between_dates_top #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire gdbd_pkg::in_word_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output gdbd_pkg::out_word_t      out_data
);
  import gdbd_pkg::*;

  logic      advance;
  logic      v1_r, v2_r, out_valid_r;
  logic      inc1_r, inc2_r;
  date_t     date_a, date_b;
  lane_res_t res_a, res_b;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  assign date_a = '{day: in_data.first_day, month: in_data.first_month,
                    year: in_data.first_year};
  assign date_b = '{day: in_data.second_day, month: in_data.second_month,
                    year: in_data.second_year};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inc1_r <= in_data.include_end_day;
      inc2_r <= inc1_r;
    end
  end

  gdbd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_a (
    .clk  (clk),
    .en   (advance),
    .date (date_a),
    .res  (res_a)
  );

  gdbd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_b (
    .clk  (clk),
    .en   (advance),
    .date (date_b),
    .res  (res_b)
  );

  gdbd_merge u_merge (
    .clk   (clk),
    .en    (advance),
    .res_a (res_a),
    .res_b (res_b),
    .inc   (inc2_r),
    .word  (out_data)
  );

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/gdbd_lane.sv
// ----------------------------------------------------------------------------
// gdbd_lane
// Two-stage conversion of one date to a day number, with 0001-01-01 as day 1.
// ----------------------------------------------------------------------------
`default_nettype none

module gdbd_lane #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire gdbd_pkg::date_t   date,
  output gdbd_pkg::lane_res_t    res
);
  import gdbd_pkg::*;

  logic [YEAR_W-1:0]  p;
  logic               range_ok_nxt;
  logic               len_ok_nxt;
  logic               feb29_nxt;

  logic [COUNT_W-1:0] p365_r;
  logic [11:0]        p4_r;
  logic [QUOT_W-1:0]  q100p_r, q400p_r, q100y_r, q400y_r;
  logic               y4_r;
  logic [BASE_W-1:0]  base_r;
  logic               after_feb_r;
  logic               range_ok_r;
  logic               len_ok_r;
  logic               feb29_r;

  logic               leap;
  lane_res_t          res_nxt;
  lane_res_t          res_r;

  always_comb begin
    p            = date.year - YEAR_W'(1);
    range_ok_nxt = (date.month >= MONTH_JAN) && (date.month <= MONTH_DEC) &&
                   (date.year != '0) && (date.day != '0) &&
                   ({1'b0, date.year} <= 15'(MAX_YEAR));
    len_ok_nxt   = date.day <= month_length(date.month);
    feb29_nxt    = (date.month == MONTH_FEB) && (date.day == FEB_LEAP_DAY);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p365_r      <= COUNT_W'(p) * COUNT_W'(DAYS_IN_YEAR);
      p4_r        <= p[YEAR_W-1:2];
      q100p_r     <= div25(p[YEAR_W-1:2]);
      q400p_r     <= div25({2'b00, p[YEAR_W-1:4]});
      q100y_r     <= div25(date.year[YEAR_W-1:2]);
      q400y_r     <= div25({2'b00, date.year[YEAR_W-1:4]});
      y4_r        <= (date.year[1:0] == 2'b00);
      base_r      <= days_before_month(date.month) + BASE_W'(date.day);
      after_feb_r <= date.month > MONTH_FEB;
      range_ok_r  <= range_ok_nxt;
      len_ok_r    <= len_ok_nxt;
      feb29_r     <= feb29_nxt;
    end
  end

  always_comb begin
    leap          = (q400y_r != q400p_r) || (y4_r && (q100y_r == q100p_r));
    res_nxt.ok    = range_ok_r && (len_ok_r || (feb29_r && leap));
    res_nxt.count = p365_r + COUNT_W'(p4_r) - COUNT_W'(q100p_r) + COUNT_W'(q400p_r) +
                    COUNT_W'(base_r) + COUNT_W'(after_feb_r && leap);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

>>> rtl/gdbd_merge.sv
// ----------------------------------------------------------------------------
// gdbd_merge
// Combine the two lane counts into the absolute, saturated day difference (plus one when inc is set);
// an invalid lane forces the difference to zero and sets date_invalid.
`default_nettype none

module gdbd_merge (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire gdbd_pkg::lane_res_t res_a,
  input  wire gdbd_pkg::lane_res_t res_b,
  input  wire logic                inc,
  output gdbd_pkg::out_word_t      word
);
  import gdbd_pkg::*;

  logic [COUNT_W-1:0] diff;
  logic [COUNT_W:0]   total;
  out_word_t          word_nxt;
  out_word_t          word_r;

  always_comb begin
    diff  = (res_a.count >= res_b.count) ? (res_a.count - res_b.count)
                                         : (res_b.count - res_a.count);
    total = {1'b0, diff} + (COUNT_W + 1)'(inc);
    if (!(res_a.ok && res_b.ok)) begin
      word_nxt.day_difference = '0;
      word_nxt.date_invalid   = 1'b1;
    end else begin
      word_nxt.day_difference = (total > (COUNT_W + 1)'(DIFF_MAX)) ? DIFF_MAX
                                                                   : total[DIFF_W-1:0];
      word_nxt.date_invalid   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

`default_nettype wire
